### design/cdr_pkg.sv
// ----------------------------------------------------------------------------
// cdr_pkg
// Shared types and constants of the consumer directory reflector.
// ----------------------------------------------------------------------------
package cdr_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int NODE_W        = 4;
  localparam int ADDR_W        = 48;
  localparam int LOC_W         = 32;
  localparam int TAG_W         = ADDR_W - IDX_W;
  localparam int CNT_W         = 32;
  localparam int START_W       = 6;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CNT_W-1:0] TAG_STEP          = CNT_W'(32);
  localparam logic [CNT_W-1:0] SECOND_TAG_OFFSET = CNT_W'(16);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE     = 2'd0,
    CFG_TWO_ENABLE = 2'd1,
    CFG_ALL_MISSES = 2'd2,
    CFG_START_TAG  = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic               enable;
    logic               two_enable;
    logic               all_misses;
    logic               tag_load;
    logic [START_W-1:0] tag_load_value;
  } cfg_t;

  // Classified request passed from the front to the back.
  typedef struct packed {
    logic              is_record;
    logic [NODE_W-1:0] node;
    logic [ADDR_W-1:0] addr;
    logic [LOC_W-1:0]  loc;
  } item_t;

  // One directory entry as held in the RAM.
  typedef struct packed {
    logic              tag_valid;
    logic [TAG_W-1:0]  tag;
    logic [NODE_W-1:0] recent_node;
    logic [LOC_W-1:0]  recent_loc;
    logic              prior_valid;
    logic [NODE_W-1:0] prior_node;
    logic [LOC_W-1:0]  prior_loc;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### design/cdr_ram.sv
// ----------------------------------------------------------------------------
// cdr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/cdr_front.sv
// ----------------------------------------------------------------------------
// cdr_front
// Accepts input requests, drops those that have no effect and queues the rest
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module cdr_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cdr_pkg::cfg_t         cfg_i,
  input  logic                  clearing_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  action_i,
  input  logic [3:0]            node_i,
  input  logic [47:0]           block_address_i,
  input  logic [31:0]           location_i,
  input  logic                  read_not_predicted_i,
  input  logic                  coherence_fill_i,
  input  logic                  fetch_i,
  output logic                  q_valid_o,
  output cdr_pkg::item_t        q_item_o,
  input  logic                  q_pop_i
);
  import cdr_pkg::*;

  item_t       mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        keep;
  logic        push;
  item_t       new_item;

  // While enabled, only records and requests that pass the filter reach the directory.
  always_comb begin
    keep = 1'b0;
    if (cfg_i.enable) begin
      if (!action_i) begin
        keep = 1'b1;
      end else begin
        keep = read_not_predicted_i && !fetch_i && (cfg_i.all_misses || coherence_fill_i);
      end
    end
  end

  assign in_stall_o = clearing_i || (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o && keep;

  always_comb begin
    new_item.is_record = !action_i;
    new_item.node      = node_i;
    new_item.addr      = block_address_i;
    new_item.loc       = location_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (q_pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push && !q_pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && q_pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

  assign q_valid_o = (count_q != 2'd0);
  assign q_item_o  = mem_q[rd_ptr_q];

endmodule

### design/cdr_back.sv
// ----------------------------------------------------------------------------
// cdr_back
// Carries out queued requests against the directory RAM: read, then update
// for records or emit stream requests for misses, through one result register.
// ----------------------------------------------------------------------------
module cdr_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cdr_pkg::cfg_t         cfg_i,
  output logic                  clearing_o,
  input  logic                  q_valid_i,
  input  cdr_pkg::item_t        q_item_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [3:0]            dest_node_o,
  output logic [3:0]            requester_node_o,
  output logic [47:0]           request_address_o,
  output logic [31:0]           stream_location_o,
  output logic                  tag_valid_o,
  output logic [31:0]           stream_tag_o,
  output logic                  last_o
);
  import cdr_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SECOND
  } state_e;

  state_e             state_q;
  logic [IDX_W-1:0]   clr_q;
  item_t              item_q;
  logic [CNT_W-1:0]   counter_q;
  logic [NODE_W-1:0]  sec_node_q;
  logic [LOC_W-1:0]   sec_loc_q;
  logic [CNT_W-1:0]   sec_tag_q;

  logic               out_valid_q;
  logic [NODE_W-1:0]  dest_q;
  logic [NODE_W-1:0]  req_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [LOC_W-1:0]   loc_q;
  logic               tv_q;
  logic [CNT_W-1:0]   tag_q;
  logic               last_q;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic               ram_re;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             ent;
  logic               hit;
  logic               out_free;
  logic               dual;
  logic [CNT_W-1:0]   counter_next;
  logic               out_load;
  logic               counter_adv;

  assign ent          = entry_t'(ram_rdata);
  assign hit          = ent.tag_valid && (ent.tag == item_q.addr[ADDR_W-1:IDX_W]);
  assign out_free     = !out_valid_q || !out_stall_i;
  assign dual         = cfg_i.two_enable && ent.prior_valid;
  assign counter_next = counter_q + TAG_STEP;

  // A new result enters the output register this cycle.
  assign out_load    = out_free && ((state_q == ST_LOOKUP && !item_q.is_record && hit) ||
                                    (state_q == ST_SECOND));
  assign counter_adv = out_load && (state_q == ST_LOOKUP) && dual;

  assign ram_re  = (state_q == ST_IDLE) && q_valid_i;
  assign q_pop_o = ram_re;

  // Record update: a hit shifts recent into prior, a miss takes the entry over.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = item_q.addr[IDX_W-1:0];
    ram_wdata = ent;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (state_q == ST_LOOKUP && item_q.is_record) begin
      ram_we = 1'b1;
      if (hit) begin
        ram_wdata.prior_valid = 1'b1;
        ram_wdata.prior_node  = ent.recent_node;
        ram_wdata.prior_loc   = ent.recent_loc;
      end else begin
        ram_wdata.tag_valid   = 1'b1;
        ram_wdata.tag         = item_q.addr[ADDR_W-1:IDX_W];
        ram_wdata.prior_valid = 1'b0;
      end
      ram_wdata.recent_node = item_q.node;
      ram_wdata.recent_loc  = item_q.loc;
    end
  end

  cdr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (q_item_i.addr[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      counter_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.tag_load) begin
        counter_q <= CNT_W'(cfg_i.tag_load_value);
      end else if (counter_adv) begin
        counter_q <= counter_next;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (&clr_q) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid_i) begin
            item_q  <= q_item_i;
            state_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (item_q.is_record || !hit) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            dest_q      <= ent.recent_node;
            req_q       <= item_q.node;
            addr_q      <= item_q.addr;
            loc_q       <= ent.recent_loc;
            if (dual) begin
              tv_q       <= 1'b1;
              tag_q      <= counter_next;
              last_q     <= 1'b0;
              sec_node_q <= ent.prior_node;
              sec_loc_q  <= ent.prior_loc;
              sec_tag_q  <= counter_next + SECOND_TAG_OFFSET;
              state_q    <= ST_SECOND;
            end else begin
              tv_q    <= 1'b0;
              tag_q   <= '0;
              last_q  <= 1'b1;
              state_q <= ST_IDLE;
            end
          end
        end
        ST_SECOND: begin
          if (out_free) begin
            dest_q      <= sec_node_q;
            loc_q       <= sec_loc_q;
            tv_q        <= 1'b1;
            tag_q       <= sec_tag_q;
            last_q      <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign clearing_o        = (state_q == ST_CLEAR);
  assign out_valid_o       = out_valid_q;
  assign dest_node_o       = dest_q;
  assign requester_node_o  = req_q;
  assign request_address_o = addr_q;
  assign stream_location_o = loc_q;
  assign tag_valid_o       = tv_q;
  assign stream_tag_o      = tag_q;
  assign last_o            = last_q;

endmodule

### design/consumer_directory_reflector_unit.sv
// ----------------------------------------------------------------------------
// consumer_directory_reflector_unit
// Per-block directory of the two latest consumers; reflects filtered misses
// as stream requests to them.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake                 Payload
//   input     in         in_valid_i / in_stall_o   action .. fetch
//   result    out        out_valid_o / out_stall_i dest_node .. last
//   config    in         cfg_we_i                  cfg_index_i, cfg_data_i
//
// A queued request passes through the back end as a RAM read, then an update or
// the first result; a double reflect adds a second result, an order set by the
// read-modify-write of the single directory RAM and the one result register.
// Filtered requests never reach the back end. After reset a clearing pass over
// all TABLE_ENTRIES (1024) entries stalls the input. Either side may stall on
// its own: a two-entry queue parts the front from the back, and the result
// register holds its request until taken.
// ----------------------------------------------------------------------------
module consumer_directory_reflector_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [3:0]  node_i,
  input  logic [47:0] block_address_i,
  input  logic [31:0] location_i,
  input  logic        read_not_predicted_i,
  input  logic        coherence_fill_i,
  input  logic        fetch_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  dest_node_o,
  output logic [3:0]  requester_node_o,
  output logic [47:0] request_address_o,
  output logic [31:0] stream_location_o,
  output logic        tag_valid_o,
  output logic [31:0] stream_tag_o,
  output logic        last_o
);
  import cdr_pkg::*;

  logic  enable_q;
  logic  two_enable_q;
  logic  all_misses_q;
  cfg_t  cfg;
  logic  clearing;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b1;
      two_enable_q <= 1'b1;
      all_misses_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_ENABLE:     enable_q     <= cfg_data_i[0];
        CFG_TWO_ENABLE: two_enable_q <= cfg_data_i[0];
        CFG_ALL_MISSES: all_misses_q <= cfg_data_i[0];
        CFG_START_TAG:  ;
        default:        ;
      endcase
    end
  end

  // The start tag lives only as the counter's load value.
  always_comb begin
    cfg.enable         = enable_q;
    cfg.two_enable     = two_enable_q;
    cfg.all_misses     = all_misses_q;
    cfg.tag_load       = cfg_we_i && (cfg_index_e'(cfg_index_i) == CFG_START_TAG);
    cfg.tag_load_value = cfg_data_i;
  end

  cdr_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg),
    .clearing_i           (clearing),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .action_i             (action_i),
    .node_i               (node_i),
    .block_address_i      (block_address_i),
    .location_i           (location_i),
    .read_not_predicted_i (read_not_predicted_i),
    .coherence_fill_i     (coherence_fill_i),
    .fetch_i              (fetch_i),
    .q_valid_o            (q_valid),
    .q_item_o             (q_item),
    .q_pop_i              (q_pop)
  );

  cdr_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .clearing_o        (clearing),
    .q_valid_i         (q_valid),
    .q_item_i          (q_item),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .dest_node_o       (dest_node_o),
    .requester_node_o  (requester_node_o),
    .request_address_o (request_address_o),
    .stream_location_o (stream_location_o),
    .tag_valid_o       (tag_valid_o),
    .stream_tag_o      (stream_tag_o),
    .last_o            (last_o)
  );

endmodule
